### rtl/tocg_pkg.sv
// Shared types, widths and codes for the truncated-octahedron chain gather block.
package tocg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int EDGE_W    = 31;
	localparam int RECIP_W   = 32;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = DIFF_W + RECIP_W;
	localparam int SH        = FRAC_BITS + 31;
	localparam int NM_W      = PROD_W - SH + 1;
	localparam int N_W       = NM_W + 1;
	localparam int A_W       = EDGE_W + NM_W + 2;
	localparam int SUM_W     = A_W + 4;
	localparam int R_W       = A_W + 2;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;
	localparam int NAXES     = 3;

	localparam logic [EDGE_W-1:0]  BOX_EDGE_RESET = EDGE_W'(65536);
	localparam logic [RECIP_W-1:0] RECIP_RESET    = RECIP_W'(64'h8000_0000);

	localparam logic REG_BOX_EDGE = 1'b0;
	localparam logic REG_RECIP    = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [N_W-1:0]     count_t;
	typedef logic signed [A_W-1:0]     red_t;
	typedef logic signed [R_W-1:0]     wide_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RED,
		ST_TST,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic red;
		logic tst;
		logic load_out;
	} dp_cmd_t;

endpackage

### rtl/tocg_regs.sv
// Configuration register file with APB-style access.
module tocg_regs import tocg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [CFG_DW-1:0]   pwdata,
	output logic [CFG_DW-1:0]   prdata,
	output logic                pready,
	output logic [EDGE_W-1:0]   box_edge,
	output logic [RECIP_W-1:0]  box_edge_reciprocal
);

	logic [EDGE_W-1:0]  box_edge_q;
	logic [RECIP_W-1:0] recip_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_edge_q <= BOX_EDGE_RESET;
			recip_q    <= RECIP_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BOX_EDGE: box_edge_q <= pwdata[EDGE_W-1:0];
				REG_RECIP:    recip_q    <= pwdata[RECIP_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BOX_EDGE: prdata = CFG_DW'(box_edge_q);
			REG_RECIP:    prdata = CFG_DW'(recip_q);
			default:      prdata = '0;
		endcase
	end

	assign box_edge            = box_edge_q;
	assign box_edge_reciprocal = recip_q;

endmodule

### rtl/tocg_ctrl.sv
// Sequencing state machine for the gather datapath and the output handshake.
module tocg_ctrl import tocg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_RED;
			ST_RED:  state_d = ST_TST;
			ST_TST:  state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_RED:  cmd.red = 1'b1;
			ST_TST:  cmd.tst = 1'b1;
			ST_FIN:  cmd.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_MUL) ##1 (state_q == ST_RED)
			##1 (state_q == ST_TST) ##1 (state_q == ST_FIN))
		else $error("item sequence broken");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside final step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && out_stall) |=> (state_q == ST_FIN))
		else $error("pending result overwritten");

endmodule

### rtl/tocg_dp.sv
// Imaging datapath: difference, image count, reduction, shift test and gather.
module tocg_dp import tocg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic [EDGE_W-1:0]  box_edge,
	input  logic [RECIP_W-1:0] box_edge_reciprocal,
	input  coord_t             pos   [NAXES],
	input  coord_t             refp  [NAXES],
	input  logic               chain_start,
	output coord_t             gathered [NAXES]
);

	coord_t anchor_q  [NAXES];
	diff_t  d_q       [NAXES];
	count_t n_q       [NAXES];
	red_t   a_q       [NAXES];
	coord_t gathered_q[NAXES];
	logic   shift_q;

	coord_t anchor_d  [NAXES];
	diff_t  d_d       [NAXES];
	count_t n_d       [NAXES];
	red_t   a_d       [NAXES];
	coord_t g_d       [NAXES];
	logic   shift_d;

	always_comb begin
		logic [DIFF_W-1:0]       mag;
		logic [PROD_W-1:0]       prod;
		logic [PROD_W-SH-1:0]    quo;
		logic                    rnd;
		logic [NM_W-1:0]         qr;
		count_t                  qs;
		red_t                    ev;
		red_t                    nv;
		logic [A_W-1:0]          abs_a;
		logic [SUM_W-1:0]        sum;
		logic [SUM_W-1:0]        lim;
		wide_t                   r2;
		wide_t                   adj;
		wide_t                   fl;
		sum     = '0;
		lim     = SUM_W'(box_edge) + SUM_W'({box_edge, 1'b0});
		ev      = red_t'($signed({1'b0, box_edge}));
		for (int i = 0; i < NAXES; i++) begin
			anchor_d[i] = chain_start ? refp[i] : gathered_q[i];
			d_d[i]      = diff_t'(pos[i]) - diff_t'(anchor_d[i]);

			mag  = d_q[i][DIFF_W-1] ? DIFF_W'(-d_q[i]) : DIFF_W'(d_q[i]);
			prod = PROD_W'(mag) * PROD_W'(box_edge_reciprocal);
			quo  = prod[PROD_W-1:SH];
			rnd  = prod[SH-1] && ((|prod[SH-2:0]) || quo[0]);
			qr   = NM_W'(quo) + NM_W'(rnd);
			qs   = $signed({1'b0, qr});
			n_d[i] = d_q[i][DIFF_W-1] ? -qs : qs;

			nv      = red_t'(n_q[i]);
			a_d[i]  = red_t'(d_q[i]) - ev * nv;

			abs_a = a_q[i][A_W-1] ? A_W'(-a_q[i]) : A_W'(a_q[i]);
			sum   = sum + SUM_W'(abs_a);

			if (!shift_q) begin
				adj = '0;
			end else if (a_q[i][A_W-1]) begin
				adj = wide_t'($signed({1'b0, box_edge}));
			end else begin
				adj = -wide_t'($signed({1'b0, box_edge}));
			end
			r2 = (wide_t'(anchor_q[i]) <<< 1) + (wide_t'(a_q[i]) <<< 1) + adj;
			fl = r2 >>> 1;
			if (r2[0] && fl[0]) begin
				fl = fl + wide_t'(1);
			end
			if (fl > wide_t'(32'sh7fff_ffff)) begin
				g_d[i] = 32'sh7fff_ffff;
			end else if (fl < -wide_t'(64'sh8000_0000)) begin
				g_d[i] = 32'sh8000_0000;
			end else begin
				g_d[i] = fl[COORD_W-1:0];
			end
		end
		shift_d = (sum << 2) > lim;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NAXES; i++) begin
			if (cmd.load_in) begin
				anchor_q[i] <= anchor_d[i];
				d_q[i]      <= d_d[i];
			end
			if (cmd.mul) n_q[i] <= n_d[i];
			if (cmd.red) a_q[i] <= a_d[i];
		end
		if (cmd.tst) shift_q <= shift_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAXES; i++) gathered_q[i] <= '0;
		end else if (cmd.load_out) begin
			for (int i = 0; i < NAXES; i++) gathered_q[i] <= g_d[i];
		end
	end

	assign gathered = gathered_q;

endmodule

### rtl/trunc_oct_chain_gather.sv
// Top level of the truncated-octahedron chain gather block.
// Sequence: an accepted item steps through the multiply, reduce, test and final
// states, and its result is registered once the output is free. Items are taken
// one at a time, as the anchor is the previous result unless chain_start is set.
// Reset: edge 1.0, reciprocal 1.0, previous atom zero; no clearing pass.
module trunc_oct_chain_gather import tocg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [CFG_AW-1:0]  paddr,
	input  logic [CFG_DW-1:0]  pwdata,
	output logic [CFG_DW-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] ref_x,
	input  logic signed [31:0] ref_y,
	input  logic signed [31:0] ref_z,
	input  logic               chain_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] gathered_x,
	output logic signed [31:0] gathered_y,
	output logic signed [31:0] gathered_z
);

	logic [EDGE_W-1:0]  box_edge;
	logic [RECIP_W-1:0] box_edge_reciprocal;
	dp_cmd_t            cmd;
	coord_t             pos  [NAXES];
	coord_t             refp [NAXES];
	coord_t             gath [NAXES];

	assign pos[0]  = pos_x;
	assign pos[1]  = pos_y;
	assign pos[2]  = pos_z;
	assign refp[0] = ref_x;
	assign refp[1] = ref_y;
	assign refp[2] = ref_z;

	assign gathered_x = gath[0];
	assign gathered_y = gath[1];
	assign gathered_z = gath[2];

	tocg_regs u_regs (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready),
		.box_edge            (box_edge),
		.box_edge_reciprocal (box_edge_reciprocal)
	);

	tocg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tocg_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.box_edge            (box_edge),
		.box_edge_reciprocal (box_edge_reciprocal),
		.pos                 (pos),
		.refp                (refp),
		.chain_start         (chain_start),
		.gathered            (gath)
	);

endmodule
